FILE: rtl/fcsg_pkg.sv
// ----------------------------------------------------------------------------
// fcsg_pkg
// Shared types, constants and span helpers for the filled-circle span
// generator.
// ----------------------------------------------------------------------------
package fcsg_pkg;

    localparam int SCREEN_WIDTH  = 480;
    localparam int SCREEN_HEIGHT = 320;
    localparam int MAX_RADIUS    = 64;
    localparam int MAX_RESULTS   = 48;

    localparam int COORD_W = 11;
    localparam int RAD_W   = 7;
    localparam int COLOR_W = 16;
    localparam int PIX_W   = 9;
    localparam int STEP_W  = 8;
    localparam int DEC_W   = 12;
    localparam int POS_W   = 12;
    localparam int CNT_W   = 6;

    localparam logic signed [POS_W-1:0] X_MAX = POS_W'(SCREEN_WIDTH - 1);
    localparam logic signed [POS_W-1:0] Y_LIM = POS_W'(SCREEN_HEIGHT);

    typedef struct packed {
        logic load;
        logic advance;
    } cmd_t;

    typedef struct packed {
        logic last;
    } status_t;

    typedef struct packed {
        logic             ok;
        logic [PIX_W-1:0] left;
        logic [PIX_W-1:0] right;
    } span_t;

    typedef struct packed {
        logic             ok;
        logic [PIX_W-1:0] row;
    } row_t;

    function automatic span_t clip_span(input logic signed [POS_W-1:0] lo,
                                        input logic signed [POS_W-1:0] hi);
        span_t                   s;
        logic signed [POS_W-1:0] lo_c;
        logic signed [POS_W-1:0] hi_c;
        lo_c    = lo[POS_W-1] ? '0 : lo;
        hi_c    = (hi > X_MAX) ? X_MAX : hi;
        s.ok    = !(lo_c > hi_c);
        s.left  = s.ok ? lo_c[PIX_W-1:0] : '0;
        s.right = s.ok ? hi_c[PIX_W-1:0] : '0;
        return s;
    endfunction

    function automatic row_t row_chk(input logic signed [POS_W-1:0] r);
        row_t o;
        o.ok  = !r[POS_W-1] && (r < Y_LIM);
        o.row = o.ok ? r[PIX_W-1:0] : '0;
        return o;
    endfunction

endpackage

FILE: rtl/fcsg_ctrl.sv
// ----------------------------------------------------------------------------
// fcsg_ctrl
// Command handshake, iteration sequencing and output word valid.
// ----------------------------------------------------------------------------
module fcsg_ctrl
    import fcsg_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_stall,
    output logic    out_valid,
    input  logic    out_stall,
    input  status_t status,
    output cmd_t    cmd
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_RUN  = 1'b1;

    logic state_reg;
    logic state_next;
    logic out_valid_reg;
    logic out_valid_next;
    logic out_free;

    assign out_free    = !out_valid_reg || !out_stall;
    assign in_stall    = (state_reg != ST_IDLE);
    assign cmd.load    = (state_reg == ST_IDLE) && in_valid;
    assign cmd.advance = (state_reg == ST_RUN) && out_free;
    assign out_valid   = out_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (cmd.advance && status.last)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.advance)
        begin
            out_valid_next = 1'b1;
        end
        else
        begin
            out_valid_next = out_valid_reg && out_stall;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // A new word only appears as the result of a step taken while running.
    a_word_from_run: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(state_reg) == ST_RUN)
        else $error("output word appeared without a running step");

    a_accept_starts_run: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> state_reg == ST_RUN)
        else $error("accepted command did not start the iteration");

    a_no_step_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |-> !cmd.advance)
        else $error("step taken while the output word was held");

endmodule

FILE: rtl/fcsg_datapath.sv
// ----------------------------------------------------------------------------
// fcsg_datapath
// Midpoint circle iteration registers, span clipping and the output word
// register.
// ----------------------------------------------------------------------------
module fcsg_datapath
    import fcsg_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  cmd_t                      cmd,
    output status_t                   status,
    input  logic signed [COORD_W-1:0] center_x,
    input  logic signed [COORD_W-1:0] center_y,
    input  logic        [RAD_W-1:0]   radius,
    input  logic        [COLOR_W-1:0] fill_color,
    output logic        [PIX_W-1:0]   inner_row_below,
    output logic        [PIX_W-1:0]   inner_row_above,
    output logic        [PIX_W-1:0]   inner_left,
    output logic        [PIX_W-1:0]   inner_right,
    output logic        [PIX_W-1:0]   outer_row_below,
    output logic        [PIX_W-1:0]   outer_row_above,
    output logic        [PIX_W-1:0]   outer_left,
    output logic        [PIX_W-1:0]   outer_right,
    output logic        [3:0]         span_valid,
    output logic        [COLOR_W-1:0] span_color,
    output logic                      last_step
);

    logic signed [STEP_W-1:0]  x_reg;
    logic signed [STEP_W-1:0]  y_reg;
    logic signed [DEC_W-1:0]   d_reg;
    logic        [CNT_W-1:0]   cnt_reg;
    logic signed [COORD_W-1:0] cx_reg;
    logic signed [COORD_W-1:0] cy_reg;
    logic        [COLOR_W-1:0] color_reg;

    logic        [RAD_W-1:0]   r_sat;
    logic signed [STEP_W-1:0]  x_next;
    logic signed [STEP_W-1:0]  y_next;
    logic signed [STEP_W-1:0]  diff;
    logic signed [DEC_W-1:0]   d_next;
    logic                      dec_pos;
    logic                      last;

    logic signed [POS_W-1:0]   cx_ext;
    logic signed [POS_W-1:0]   cy_ext;
    logic signed [POS_W-1:0]   x_ext;
    logic signed [POS_W-1:0]   y_ext;
    span_t                     inner;
    span_t                     outer;
    row_t                      row_ib;
    row_t                      row_ia;
    row_t                      row_ob;
    row_t                      row_oa;

    logic [PIX_W-1:0]          inner_row_below_reg;
    logic [PIX_W-1:0]          inner_row_above_reg;
    logic [PIX_W-1:0]          inner_left_reg;
    logic [PIX_W-1:0]          inner_right_reg;
    logic [PIX_W-1:0]          outer_row_below_reg;
    logic [PIX_W-1:0]          outer_row_above_reg;
    logic [PIX_W-1:0]          outer_left_reg;
    logic [PIX_W-1:0]          outer_right_reg;
    logic [3:0]                span_valid_reg;
    logic [COLOR_W-1:0]        span_color_reg;
    logic                      last_step_reg;

    assign r_sat = (radius > RAD_W'(MAX_RADIUS)) ? RAD_W'(MAX_RADIUS) : radius;

    // Decision step: x always moves on, y drops only when d is positive.
    assign dec_pos = !d_reg[DEC_W-1] && (d_reg != '0);
    assign x_next  = x_reg + STEP_W'(1);
    assign y_next  = dec_pos ? (y_reg - STEP_W'(1)) : y_reg;
    assign diff    = x_next - y_next;

    always_comb
    begin
        if (dec_pos)
        begin
            d_next = d_reg + {{(DEC_W-STEP_W-2){diff[STEP_W-1]}}, diff, 2'b00}
                     + DEC_W'(10);
        end
        else
        begin
            d_next = d_reg + {{(DEC_W-STEP_W-2){x_next[STEP_W-1]}}, x_next, 2'b00}
                     + DEC_W'(6);
        end
    end

    assign last = (y_next < x_next) || (cnt_reg == CNT_W'(MAX_RESULTS - 1));
    assign status.last = last;

    assign cx_ext = {{(POS_W-COORD_W){cx_reg[COORD_W-1]}}, cx_reg};
    assign cy_ext = {{(POS_W-COORD_W){cy_reg[COORD_W-1]}}, cy_reg};
    assign x_ext  = {{(POS_W-STEP_W){x_reg[STEP_W-1]}}, x_reg};
    assign y_ext  = {{(POS_W-STEP_W){y_reg[STEP_W-1]}}, y_reg};

    assign inner  = clip_span(cx_ext - x_ext, cx_ext + x_ext);
    assign outer  = clip_span(cx_ext - y_ext, cx_ext + y_ext);
    assign row_ib = row_chk(cy_ext + y_ext);
    assign row_ia = row_chk(cy_ext - y_ext);
    assign row_ob = row_chk(cy_ext + x_ext);
    assign row_oa = row_chk(cy_ext - x_ext);

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            x_reg     <= '0;
            y_reg     <= {1'b0, r_sat};
            d_reg     <= DEC_W'(3) - {{(DEC_W-RAD_W-1){1'b0}}, r_sat, 1'b0};
            cnt_reg   <= '0;
            cx_reg    <= center_x;
            cy_reg    <= center_y;
            color_reg <= fill_color;
        end
        else if (cmd.advance)
        begin
            x_reg   <= x_next;
            y_reg   <= y_next;
            d_reg   <= d_next;
            cnt_reg <= cnt_reg + CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.advance)
        begin
            inner_row_below_reg <= row_ib.row;
            inner_row_above_reg <= row_ia.row;
            inner_left_reg      <= inner.left;
            inner_right_reg     <= inner.right;
            outer_row_below_reg <= row_ob.row;
            outer_row_above_reg <= row_oa.row;
            outer_left_reg      <= outer.left;
            outer_right_reg     <= outer.right;
            span_valid_reg      <= {row_oa.ok && outer.ok, row_ob.ok && outer.ok,
                                    row_ia.ok && inner.ok, row_ib.ok && inner.ok};
            span_color_reg      <= color_reg;
            last_step_reg       <= last;
        end
    end

    assign inner_row_below = inner_row_below_reg;
    assign inner_row_above = inner_row_above_reg;
    assign inner_left      = inner_left_reg;
    assign inner_right     = inner_right_reg;
    assign outer_row_below = outer_row_below_reg;
    assign outer_row_above = outer_row_above_reg;
    assign outer_left      = outer_left_reg;
    assign outer_right     = outer_right_reg;
    assign span_valid      = span_valid_reg;
    assign span_color      = span_color_reg;
    assign last_step       = last_step_reg;

    // Every step is taken inside the octant, so y never falls below x.
    a_octant: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.advance |-> x_reg <= y_reg)
        else $error("iteration stepped outside the octant");

    a_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.advance |-> cnt_reg < CNT_W'(MAX_RESULTS))
        else $error("iteration exceeded the step bound");

endmodule

FILE: rtl/filled_circle_span_generator_unit.sv
// The first word of a circle is registered by the first step after the command is loaded;
// that step waits until the previous word has been taken.
// Throughput: one word a cycle while the output is not stalled; a circle of radius r gives
// about 0.71*r+1 words, 46 at the saturated radius of 64, set by the one-step-a-cycle
// midpoint loop. A new command is taken in the cycle after the last word is computed.
// Reset: rst_n clears the sequencer and output valid; payload registers are not reset.
// ----------------------------------------------------------------------------
// filled_circle_span_generator_unit
// Turns one filled-circle command into a series of clipped horizontal span words.
// ----------------------------------------------------------------------------
module filled_circle_span_generator_unit
    import fcsg_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic signed [COORD_W-1:0] center_x,
    input  logic signed [COORD_W-1:0] center_y,
    input  logic        [RAD_W-1:0]   radius,
    input  logic        [COLOR_W-1:0] fill_color,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic        [PIX_W-1:0]   inner_row_below,
    output logic        [PIX_W-1:0]   inner_row_above,
    output logic        [PIX_W-1:0]   inner_left,
    output logic        [PIX_W-1:0]   inner_right,
    output logic        [PIX_W-1:0]   outer_row_below,
    output logic        [PIX_W-1:0]   outer_row_above,
    output logic        [PIX_W-1:0]   outer_left,
    output logic        [PIX_W-1:0]   outer_right,
    output logic        [3:0]         span_valid,
    output logic        [COLOR_W-1:0] span_color,
    output logic                      last_step
);

    cmd_t    cmd;
    status_t status;

    fcsg_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd)
    );

    fcsg_datapath u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .status          (status),
        .center_x        (center_x),
        .center_y        (center_y),
        .radius          (radius),
        .fill_color      (fill_color),
        .inner_row_below (inner_row_below),
        .inner_row_above (inner_row_above),
        .inner_left      (inner_left),
        .inner_right     (inner_right),
        .outer_row_below (outer_row_below),
        .outer_row_above (outer_row_above),
        .outer_left      (outer_left),
        .outer_right     (outer_right),
        .span_valid      (span_valid),
        .span_color      (span_color),
        .last_step       (last_step)
    );

endmodule
